[design/i2cs_pkg.sv]
// ----------------------------------------------------------------------------
// i2cs_pkg
// types, codes and constants shared by the register transfer sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cs_pkg;

  // default burst limit and timeout after reset
  localparam int unsigned MAX_BURST_DEF = 8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

  // bus engine status codes
  localparam logic [7:0] ST_START   = 8'h08;
  localparam logic [7:0] ST_RSTART  = 8'h10;
  localparam logic [7:0] ST_SAW_ACK = 8'h18;
  localparam logic [7:0] ST_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_SAR_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_RX_NACK = 8'h58;
  localparam logic [7:0] READ_BIT   = 8'h01;

  // outcome codes beyond the per-step error codes
  localparam logic [3:0] OUT_OK            = 4'd0;
  localparam logic [3:0] OUT_RX_ACK_ERR    = 4'd7;
  localparam logic [3:0] OUT_RX_LAST_ERR   = 4'd8;
  localparam logic [3:0] OUT_EVENT_TIMEOUT = 4'd9;
  localparam logic [3:0] OUT_STOP_TIMEOUT  = 4'd10;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_STATUS    = 2'd1,
    OP_TICK      = 2'd2,
    OP_STOP_DONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5
  } act_t;

  // phase codes double as the error outcome of their step
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_SAW    = 4'd2,
    PH_REG    = 4'd3,
    PH_DATA   = 4'd4,
    PH_RSTART = 4'd5,
    PH_SAR    = 4'd6,
    PH_RX     = 4'd7,
    PH_STOP   = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       command;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [3:0] read_count;
    logic [7:0] status_code;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [2:0] rx_index;
    logic       done_res;
    logic [3:0] outcome;
    logic       busy_res;
  } out_item_t;

endpackage

`default_nettype wire

[design/i2cs_ifs.sv]
// ----------------------------------------------------------------------------
// i2cs channel interfaces
// valid/ready channels for commands, results and the timeout register
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       command;
  logic [7:0] device_address;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic [3:0] read_count;
  logic [7:0] status_code;
  logic [7:0] received_byte;

  modport source (
    output valid, opcode, command, device_address, register_address,
           write_data, read_count, status_code, received_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, command, device_address, register_address,
           write_data, read_count, status_code, received_byte,
    output ready
  );
endinterface

interface i2cs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [2:0] rx_index;
  logic       done_res;
  logic [3:0] outcome;
  logic       busy_res;

  modport source (
    output valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res,
           outcome, busy_res,
    input  ready
  );
  modport sink (
    input  valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res,
           outcome, busy_res,
    output ready
  );
endinterface

interface i2cs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[design/i2c_register_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer
// i2c master register write / burst read sequencer over a byte bus engine
// ----------------------------------------------------------------------------
// Each input transfer (start command, bus status event, tick, stop completed)
// produces exactly one result transfer telling the bus engine what to do next
// (start, send a byte, receive with ack or nack, stop) plus any received byte
// with its index, and a done flag with an outcome code when the transaction
// ends. It takes one transfer per clock while the result side keeps up: an
// input register feeds a single step of next-state logic that writes the
// result register, so an item passes the input register and then the result
// register on its way out, and a new item can be accepted every cycle.
// timeout_limit may only be written while no transaction is running and no
// item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_transfer_sequencer #(
  parameter int unsigned MAX_BURST = i2cs_pkg::MAX_BURST_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  i2cs_in_if.sink     in_ch,
  i2cs_out_if.source  out_ch,
  i2cs_cfg_if.sink    cfg_ch
);

  // timeout register, write always taken
  logic [15:0] timeout_limit_r;

  i2cs_pkg::in_item_t  in_item;
  i2cs_pkg::in_item_t  s_item;
  i2cs_pkg::out_item_t out_item;
  logic                s_valid;
  logic                take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= i2cs_pkg::TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      timeout_limit_r <= cfg_ch.data;
    end
  end

  // pack the input channel payload
  assign in_item.opcode           = in_ch.opcode;
  assign in_item.command          = in_ch.command;
  assign in_item.device_address   = in_ch.device_address;
  assign in_item.register_address = in_ch.register_address;
  assign in_item.write_data       = in_ch.write_data;
  assign in_item.read_count       = in_ch.read_count;
  assign in_item.status_code      = in_ch.status_code;
  assign in_item.received_byte    = in_ch.received_byte;

  i2cs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .take     (take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  i2cs_engine #(
    .MAX_BURST (MAX_BURST)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_valid       (s_valid),
    .s_item        (s_item),
    .timeout_limit (timeout_limit_r),
    .take          (take),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_item      (out_item)
  );

  // unpack the result register onto the output channel
  assign out_ch.action   = out_item.action;
  assign out_ch.tx_byte  = out_item.tx_byte;
  assign out_ch.rx_valid = out_item.rx_valid;
  assign out_ch.rx_byte  = out_item.rx_byte;
  assign out_ch.rx_index = out_item.rx_index;
  assign out_ch.done_res = out_item.done_res;
  assign out_ch.outcome  = out_item.outcome;
  assign out_ch.busy_res = out_item.busy_res;

endmodule

`default_nettype wire

[design/i2cs_in_reg.sv]
// ----------------------------------------------------------------------------
// i2cs_in_reg
// input register stage, refilled in the same cycle it is drained
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire i2cs_pkg::in_item_t in_item,
  input  wire logic              take,
  output logic                   s_valid,
  output i2cs_pkg::in_item_t     s_item
);

  logic               valid_r;
  i2cs_pkg::in_item_t item_r;

  assign in_ready = !valid_r || take;
  assign s_valid  = valid_r;
  assign s_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[design/i2cs_engine.sv]
// ----------------------------------------------------------------------------
// i2cs_engine
// transaction state, one step per item, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_engine #(
  parameter int unsigned MAX_BURST = i2cs_pkg::MAX_BURST_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s_valid,
  input  wire i2cs_pkg::in_item_t s_item,
  input  wire logic [15:0]        timeout_limit,
  output logic                    take,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output i2cs_pkg::out_item_t     out_item
);

  localparam int unsigned CntW = $clog2(MAX_BURST + 1);
  localparam int unsigned NW   = (CntW > 4) ? CntW : 4;

  // state
  i2cs_pkg::phase_t phase_r, phase_nxt;
  logic             is_read_r, is_read_nxt;
  logic [7:0]       dev_r, dev_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [CntW-1:0]  wanted_r, wanted_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic [3:0]       pend_r, pend_nxt;

  logic                valid_r;
  i2cs_pkg::out_item_t res_r, res;

  // shared decode
  i2cs_pkg::op_t   op;
  logic [7:0]      expect_code;
  logic            status_ok;
  logic            last;
  logic            next_last;
  logic [CntW:0]   pos_p1;
  logic [CntW:0]   pos_p2;
  logic [15:0]     wait_inc;
  logic            timed_out;
  logic [NW-1:0]   n_raw;
  logic [NW-1:0]   n_clamp;

  assign take      = s_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_item  = res_r;

  assign op        = i2cs_pkg::op_t'(s_item.opcode);
  assign pos_p1    = (CntW+1)'(pos_r) + (CntW+1)'(1);
  assign pos_p2    = (CntW+1)'(pos_r) + (CntW+1)'(2);
  assign last      = pos_p1 >= (CntW+1)'(wanted_r);
  assign next_last = pos_p2 >= (CntW+1)'(wanted_r);
  assign wait_inc  = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  assign timed_out = wait_inc > timeout_limit;
  assign status_ok = s_item.status_code == expect_code;

  // read count clamped to 1..MAX_BURST
  always_comb begin
    n_raw   = NW'(s_item.read_count);
    n_clamp = n_raw;
    if (n_raw == '0) begin
      n_clamp = NW'(1);
    end
    if (n_raw > NW'(MAX_BURST)) begin
      n_clamp = NW'(MAX_BURST);
    end
  end

  always_comb begin
    case (phase_r)
      i2cs_pkg::PH_START:  expect_code = i2cs_pkg::ST_START;
      i2cs_pkg::PH_SAW:    expect_code = i2cs_pkg::ST_SAW_ACK;
      i2cs_pkg::PH_REG:    expect_code = i2cs_pkg::ST_TX_ACK;
      i2cs_pkg::PH_DATA:   expect_code = i2cs_pkg::ST_TX_ACK;
      i2cs_pkg::PH_RSTART: expect_code = i2cs_pkg::ST_RSTART;
      i2cs_pkg::PH_SAR:    expect_code = i2cs_pkg::ST_SAR_ACK;
      default:             expect_code = last ? i2cs_pkg::ST_RX_NACK : i2cs_pkg::ST_RX_ACK;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (op)
      i2cs_pkg::OP_START: begin
        if (phase_r == i2cs_pkg::PH_IDLE) begin
          phase_nxt = i2cs_pkg::PH_START;
        end
      end
      i2cs_pkg::OP_STATUS: begin
        if (phase_r != i2cs_pkg::PH_IDLE && phase_r != i2cs_pkg::PH_STOP) begin
          if (!status_ok) begin
            phase_nxt = i2cs_pkg::PH_STOP;
          end else begin
            case (phase_r)
              i2cs_pkg::PH_START:  phase_nxt = i2cs_pkg::PH_SAW;
              i2cs_pkg::PH_SAW:    phase_nxt = i2cs_pkg::PH_REG;
              i2cs_pkg::PH_REG:    phase_nxt = is_read_r ? i2cs_pkg::PH_RSTART
                                                         : i2cs_pkg::PH_DATA;
              i2cs_pkg::PH_DATA:   phase_nxt = i2cs_pkg::PH_STOP;
              i2cs_pkg::PH_RSTART: phase_nxt = i2cs_pkg::PH_SAR;
              i2cs_pkg::PH_SAR:    phase_nxt = i2cs_pkg::PH_RX;
              default:             phase_nxt = last ? i2cs_pkg::PH_STOP : i2cs_pkg::PH_RX;
            endcase
          end
        end
      end
      i2cs_pkg::OP_TICK: begin
        if (phase_r != i2cs_pkg::PH_IDLE && timed_out) begin
          phase_nxt = i2cs_pkg::PH_IDLE;
        end
      end
      i2cs_pkg::OP_STOP_DONE: begin
        if (phase_r == i2cs_pkg::PH_STOP) begin
          phase_nxt = i2cs_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // result fields and datapath state
  always_comb begin
    res         = '0;
    is_read_nxt = is_read_r;
    dev_nxt     = dev_r;
    reg_nxt     = reg_r;
    data_nxt    = data_r;
    wanted_nxt  = wanted_r;
    pos_nxt     = pos_r;
    wait_nxt    = wait_r;
    pend_nxt    = pend_r;
    res.action  = i2cs_pkg::ACT_NONE;
    case (op)
      i2cs_pkg::OP_START: begin
        if (phase_r == i2cs_pkg::PH_IDLE) begin
          is_read_nxt = s_item.command;
          dev_nxt     = s_item.device_address;
          reg_nxt     = s_item.register_address;
          data_nxt    = s_item.write_data;
          wanted_nxt  = CntW'(n_clamp);
          pos_nxt     = '0;
          wait_nxt    = '0;
          pend_nxt    = i2cs_pkg::OUT_OK;
          res.action  = i2cs_pkg::ACT_START;
        end
      end
      i2cs_pkg::OP_STATUS: begin
        if (phase_r != i2cs_pkg::PH_IDLE && phase_r != i2cs_pkg::PH_STOP) begin
          wait_nxt = '0;
          if (!status_ok) begin
            if (phase_r == i2cs_pkg::PH_RX) begin
              pend_nxt = last ? i2cs_pkg::OUT_RX_LAST_ERR : i2cs_pkg::OUT_RX_ACK_ERR;
            end else begin
              pend_nxt = 4'(phase_r);
            end
            res.action = i2cs_pkg::ACT_STOP;
          end else begin
            case (phase_r)
              i2cs_pkg::PH_START: begin
                res.action  = i2cs_pkg::ACT_SEND;
                res.tx_byte = dev_r;
              end
              i2cs_pkg::PH_SAW: begin
                res.action  = i2cs_pkg::ACT_SEND;
                res.tx_byte = reg_r;
              end
              i2cs_pkg::PH_REG: begin
                if (is_read_r) begin
                  res.action = i2cs_pkg::ACT_START;
                end else begin
                  res.action  = i2cs_pkg::ACT_SEND;
                  res.tx_byte = data_r;
                end
              end
              i2cs_pkg::PH_DATA: begin
                pend_nxt   = i2cs_pkg::OUT_OK;
                res.action = i2cs_pkg::ACT_STOP;
              end
              i2cs_pkg::PH_RSTART: begin
                res.action  = i2cs_pkg::ACT_SEND;
                res.tx_byte = dev_r | i2cs_pkg::READ_BIT;
              end
              i2cs_pkg::PH_SAR: begin
                res.action = (wanted_r <= CntW'(1)) ? i2cs_pkg::ACT_NACK
                                                    : i2cs_pkg::ACT_ACK;
              end
              default: begin
                // data byte phase
                res.rx_valid = 1'b1;
                res.rx_byte  = s_item.received_byte;
                res.rx_index = 3'(pos_r);
                pos_nxt      = CntW'(pos_p1);
                if (last) begin
                  pend_nxt   = i2cs_pkg::OUT_OK;
                  res.action = i2cs_pkg::ACT_STOP;
                end else begin
                  res.action = next_last ? i2cs_pkg::ACT_NACK : i2cs_pkg::ACT_ACK;
                end
              end
            endcase
          end
        end
      end
      i2cs_pkg::OP_TICK: begin
        if (phase_r != i2cs_pkg::PH_IDLE) begin
          wait_nxt = wait_inc;
          if (timed_out) begin
            if (phase_r == i2cs_pkg::PH_STOP) begin
              res.outcome = i2cs_pkg::OUT_STOP_TIMEOUT;
            end else begin
              res.action  = i2cs_pkg::ACT_STOP;
              res.outcome = i2cs_pkg::OUT_EVENT_TIMEOUT;
            end
            res.done_res = 1'b1;
            wait_nxt     = '0;
          end
        end
      end
      i2cs_pkg::OP_STOP_DONE: begin
        if (phase_r == i2cs_pkg::PH_STOP) begin
          res.done_res = 1'b1;
          res.outcome  = pend_r;
          wait_nxt     = '0;
        end
      end
      default: res.action = i2cs_pkg::ACT_NONE;
    endcase
    res.busy_res = phase_nxt != i2cs_pkg::PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cs_pkg::PH_IDLE;
      is_read_r <= 1'b0;
      dev_r     <= '0;
      reg_r     <= '0;
      data_r    <= '0;
      wanted_r  <= '0;
      pos_r     <= '0;
      wait_r    <= '0;
      pend_r    <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      dev_r     <= dev_nxt;
      reg_r     <= reg_nxt;
      data_r    <= data_nxt;
      wanted_r  <= wanted_nxt;
      pos_r     <= pos_nxt;
      wait_r    <= wait_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
